// ----- src/xrg_pkg.sv -----
// Shared constants and types for the xoshiro256** generator.
package xrg_pkg;

   localparam logic [1:0] CMD_RESEED  = 2'd0;
   localparam logic [1:0] CMD_RAW     = 2'd1;
   localparam logic [1:0] CMD_BOUNDED = 2'd2;

   localparam logic [63:0] MIX_GAMMA = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B = 64'h94D049BB133111EB;

   // Datapath operations issued by the controller.
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;  // capture request, clear result
   localparam logic [3:0] OP_MIX_ADD   = 4'd2;  // acc += gamma, z = acc ^ (acc >> 30)
   localparam logic [3:0] OP_MUL_A     = 4'd3;  // start multiply of z by constant A
   localparam logic [3:0] OP_MIX_MID   = 4'd4;  // z = p ^ (p >> 27)
   localparam logic [3:0] OP_MUL_B     = 4'd5;  // start multiply of z by constant B
   localparam logic [3:0] OP_MIX_STORE = 4'd6;  // word[idx] = p ^ (p >> 31)
   localparam logic [3:0] OP_DRAW      = 4'd7;  // scramble and advance state
   localparam logic [3:0] OP_DIV_START = 4'd8;  // start raw mod span
   localparam logic [3:0] OP_FINISH    = 4'd9;  // form the bounded result
   localparam logic [3:0] OP_EQUAL     = 4'd10; // equal bounds result

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] word_idx;
   } cmd_type;

   typedef struct packed {
      logic       mul_busy;
      logic       div_busy;
      logic       bounds_equal;
      logic [1:0] command;
   } status_type;

endpackage

// ----- src/xrg_datapath.sv -----
// Datapath: generator state, seeding mixer, shared multiplier and divider.
module xrg_datapath
   import xrg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   status,
   input  logic [1:0]   req_command,
   input  logic [63:0]  req_seed_value,
   input  logic [31:0]  req_range_low,
   input  logic [31:0]  req_range_high,
   output logic [63:0]  raw_value,
   output logic [31:0]  ranged_value,
   output logic         span_error
);

   logic [63:0] word_ff [4];
   logic [63:0] word_in [4];
   logic [1:0]  command_ff;
   logic [63:0] acc_ff, acc_in, z_ff, z_in;
   logic [31:0] low_ff, high_ff;
   logic [63:0] raw_ff, raw_in;
   logic [31:0] ranged_ff, ranged_in;
   logic        err_ff, err_in;

   // Multiplier: 64x64 low half built from a 16x64 partial product per cycle,
   // accumulated over the four 16-bit slices of the constant.
   logic [63:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in, prod_ff, prod_in;
   logic [2:0]  mul_cnt_ff, mul_cnt_in;
   logic [79:0] mul_part;

   // Restoring divider: one quotient bit per cycle.
   logic [63:0] dvd_ff, dvd_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [6:0]  div_cnt_ff, div_cnt_in;
   logic [64:0] rem_shift, rem_sub;

   logic [63:0] span;
   logic [31:0] diff;
   logic [63:0] t17, s1x5, rot;

   assign diff = high_ff - low_ff;
   assign span = {{32{diff[31]}}, diff} + 64'd1;
   assign mul_part = mul_b_ff[15:0] * mul_a_ff;
   assign rem_shift = {rem_ff, dvd_ff[63]};
   assign rem_sub = rem_shift - {1'b0, dvs_ff};
   assign s1x5 = word_ff[1] * 64'd5;
   assign rot = {s1x5[56:0], s1x5[63:57]};
   assign t17 = word_ff[1] << 17;

   always_comb begin
      logic [63:0] s2, s3, s1, s0;
      word_in = word_ff;
      acc_in = acc_ff;
      z_in = z_ff;
      raw_in = raw_ff;
      ranged_in = ranged_ff;
      err_in = err_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      prod_in = prod_ff;
      mul_cnt_in = mul_cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      div_cnt_in = div_cnt_ff;
      s2 = word_ff[2] ^ word_ff[0];
      s3 = word_ff[3] ^ word_ff[1];
      s1 = word_ff[1] ^ s2;
      s0 = word_ff[0] ^ s3;

      if (mul_cnt_ff != 3'd0) begin
         prod_in = prod_ff + mul_part[63:0];
         mul_a_in = mul_a_ff << 16;
         mul_b_in = mul_b_ff >> 16;
         mul_cnt_in = mul_cnt_ff - 3'd1;
      end
      if (div_cnt_ff != 7'd0) begin
         if (!rem_sub[64]) begin
            rem_in = rem_sub[63:0];
         end else begin
            rem_in = rem_shift[63:0];
         end
         dvd_in = dvd_ff << 1;
         div_cnt_in = div_cnt_ff - 7'd1;
      end

      unique case (cmd.op) inside
         OP_LOAD: begin
            acc_in = req_seed_value;
            raw_in = '0;
            ranged_in = '0;
            err_in = 1'b0;
         end
         OP_MIX_ADD: begin
            acc_in = acc_ff + MIX_GAMMA;
            z_in = acc_in ^ (acc_in >> 30);
         end
         OP_MUL_A, OP_MUL_B: begin
            mul_a_in = z_ff;
            mul_b_in = (cmd.op == OP_MUL_A) ? MIX_MUL_A : MIX_MUL_B;
            prod_in = '0;
            mul_cnt_in = 3'd4;
         end
         OP_MIX_MID: z_in = prod_ff ^ (prod_ff >> 27);
         OP_MIX_STORE: word_in[cmd.word_idx] = prod_ff ^ (prod_ff >> 31);
         OP_DRAW: begin
            z_in = {rot[60:0], 3'b000} + rot;
            if (command_ff == CMD_RAW) begin
               raw_in = z_in;
            end
            word_in[0] = s0;
            word_in[1] = s1;
            word_in[2] = s2 ^ t17;
            word_in[3] = {s3[18:0], s3[63:19]};
         end
         OP_DIV_START: begin
            dvd_in = z_ff;
            dvs_in = span;
            rem_in = '0;
            div_cnt_in = 7'd64;
         end
         OP_FINISH: begin
            if (span == 64'd0) begin
               err_in = 1'b1;
            end else begin
               ranged_in = low_ff + rem_ff[31:0];
            end
         end
         OP_EQUAL: ranged_in = low_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            word_ff[i] <= '0;
         end
         mul_cnt_ff <= '0;
         div_cnt_ff <= '0;
      end else begin
         word_ff <= word_in;
         mul_cnt_ff <= mul_cnt_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         command_ff <= req_command;
         low_ff <= req_range_low;
         high_ff <= req_range_high;
      end
      acc_ff <= acc_in;
      z_ff <= z_in;
      raw_ff <= raw_in;
      ranged_ff <= ranged_in;
      err_ff <= err_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      prod_ff <= prod_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.mul_busy = (mul_cnt_ff != 3'd0);
   assign status.div_busy = (div_cnt_ff != 7'd0);
   assign status.bounds_equal = (low_ff == high_ff);
   assign status.command = command_ff;
   assign raw_value = raw_ff;
   assign ranged_value = ranged_ff;
   assign span_error = err_ff;

endmodule

// ----- src/xrg_controller.sv -----
// Controller: sequences the datapath for each command and runs the handshake.
module xrg_controller
   import xrg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DECODE   = 4'd1;
   localparam logic [3:0] ST_MIX_ADD  = 4'd2;
   localparam logic [3:0] ST_MUL_A    = 4'd3;
   localparam logic [3:0] ST_WAIT_A   = 4'd4;
   localparam logic [3:0] ST_MIX_MID  = 4'd5;
   localparam logic [3:0] ST_MUL_B    = 4'd6;
   localparam logic [3:0] ST_WAIT_B   = 4'd7;
   localparam logic [3:0] ST_STORE    = 4'd8;
   localparam logic [3:0] ST_DRAW     = 4'd9;
   localparam logic [3:0] ST_DIV      = 4'd10;
   localparam logic [3:0] ST_WAIT_DIV = 4'd11;
   localparam logic [3:0] ST_FINISH   = 4'd12;
   localparam logic [3:0] ST_DONE     = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       accept;

   // A new item may enter while the finished one is being taken.
   assign req_stall = !(state_ff == ST_IDLE || (state_ff == ST_DONE && !rsp_stall));
   assign accept = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd.op = OP_NONE;
      cmd.word_idx = idx_ff;
      unique case (state_ff) inside
         ST_IDLE, ST_DONE: begin
            if (state_ff == ST_DONE && !rsp_stall) begin
               state_in = ST_IDLE;
            end
            if (accept) begin
               cmd.op = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            idx_in = 2'd0;
            unique case (status.command)
               CMD_RESEED: state_in = ST_MIX_ADD;
               CMD_RAW: state_in = ST_DRAW;
               CMD_BOUNDED: begin
                  if (status.bounds_equal) begin
                     cmd.op = OP_EQUAL;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_DRAW;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_MIX_ADD: begin
            cmd.op = OP_MIX_ADD;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.op = OP_MUL_A;
            state_in = ST_WAIT_A;
         end
         ST_WAIT_A: if (!status.mul_busy) state_in = ST_MIX_MID;
         ST_MIX_MID: begin
            cmd.op = OP_MIX_MID;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.op = OP_MUL_B;
            state_in = ST_WAIT_B;
         end
         ST_WAIT_B: if (!status.mul_busy) state_in = ST_STORE;
         ST_STORE: begin
            cmd.op = OP_MIX_STORE;
            idx_in = idx_ff + 2'd1;
            state_in = (idx_ff == 2'd3) ? ST_DONE : ST_MIX_ADD;
         end
         ST_DRAW: begin
            cmd.op = OP_DRAW;
            state_in = (status.command == CMD_RAW) ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_START;
            state_in = ST_WAIT_DIV;
         end
         ST_WAIT_DIV: if (!status.div_busy) state_in = ST_FINISH;
         ST_FINISH: begin
            cmd.op = OP_FINISH;
            state_in = ST_DONE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- src/xoshiro256ss_random_generator_top.sv -----
// A bounded draw uses a bit-serial divider; a reseed runs four mixing rounds,
// each with two multiplies on a shared 16x64 multiplier.
// One item at a time; the next item is accepted in the cycle its
// predecessor's result is taken. Synchronous reset zeroes the state words.
module xoshiro256ss_random_generator_top
   import xrg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_command,
   input  logic [63:0]  req_seed_value,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_raw_value,
   output logic signed [31:0] rsp_ranged_value,
   output logic         rsp_span_error
);

   cmd_type    cmd;
   status_type status;

   xrg_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   xrg_datapath u_dp (
      .clock, .reset, .cmd, .status, .req_command, .req_seed_value,
      .req_range_low, .req_range_high,
      .raw_value(rsp_raw_value),
      .ranged_value(rsp_ranged_value),
      .span_error(rsp_span_error)
   );

endmodule

// ----- sim/tb_xoshiro256ss_random_generator_top.sv -----
// Self-checking testbench for the xoshiro256** generator with splitmix64 seeding.
module tb_xoshiro256ss_random_generator_top;
   timeunit 1ns;
   timeprecision 1ps;
   import xrg_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [63:0] raw_value;
      logic [31:0] ranged_value;
      logic        span_error;
   } draw_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_command = CMD_RESEED;
   logic [63:0]        req_seed_value = '0;
   logic signed [31:0] req_range_low = '0;
   logic signed [31:0] req_range_high = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [63:0]        rsp_raw_value;
   logic signed [31:0] rsp_ranged_value;
   logic               rsp_span_error;

   logic [63:0]     gen_words [4] = '{default: 64'd0};
   draw_result_type pending_results [$];
   int              error_count = 0;
   int              items_sent = 0;
   int              results_seen = 0;
   int              idle_cycles = 0;
   int              burst_left = 0;

   xoshiro256ss_random_generator_top dut (.*);

   always #10 clock = ~clock;

   function automatic logic [63:0] rotate_left(logic [63:0] x, int k);
      return (x << k) | (x >> (64 - k));
   endfunction

   function automatic logic [63:0] splitmix_next(ref logic [63:0] acc);
      logic [63:0] z;
      acc = acc + MIX_GAMMA;
      z = acc;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      return z ^ (z >> 31);
   endfunction

   function automatic logic [63:0] advance_generator();
      logic [63:0] out, t;
      out = rotate_left(gen_words[1] * 64'd5, 7) * 64'd9;
      t = gen_words[1] << 17;
      gen_words[2] ^= gen_words[0];
      gen_words[3] ^= gen_words[1];
      gen_words[1] ^= gen_words[2];
      gen_words[0] ^= gen_words[3];
      gen_words[2] ^= t;
      gen_words[3] = rotate_left(gen_words[3], 45);
      return out;
   endfunction

   function automatic draw_result_type predict_result(logic [1:0] cmd, logic [63:0] seed,
                                                      logic [31:0] lo, logic [31:0] hi);
      draw_result_type r;
      logic [63:0] acc, span, raw;
      logic [31:0] diff;
      r = '0;
      acc = seed;
      case (cmd)
         CMD_RESEED: begin
            for (int i = 0; i < 4; i++) gen_words[i] = splitmix_next(acc);
         end
         CMD_RAW: r.raw_value = advance_generator();
         CMD_BOUNDED: begin
            if (lo == hi) begin
               r.ranged_value = lo;
            end else begin
               diff = hi - lo;
               span = {{32{diff[31]}}, diff} + 64'd1;
               raw = advance_generator();
               if (span == 0) r.span_error = 1'b1;
               else r.ranged_value = lo + 32'(raw % span);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Sender: bursts of random length separated by random gaps. Valid stays
   // high within a burst and drops only for a gap.
   task automatic send_item(logic [1:0] cmd, logic [63:0] seed,
                            logic [31:0] lo, logic [31:0] hi);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge clock);
         end
      end
      burst_left--;
      pending_results.push_back(predict_result(cmd, seed, lo, hi));
      req_valid <= 1'b1;
      req_command <= cmd;
      req_seed_value <= seed;
      req_range_low <= lo;
      req_range_high <= hi;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Receiver stall pattern: phases of no stall, light stall and heavy stall.
   always @(posedge clock) begin
      case ((results_seen / 40) % 3)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      draw_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected: raw %h ranged %h err %b", $time,
                     rsp_raw_value, rsp_ranged_value, rsp_span_error);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_raw_value !== want.raw_value) begin
               $display("%0t: raw_value expected %h actual %h", $time,
                        want.raw_value, rsp_raw_value);
               error_count++;
            end
            if (rsp_ranged_value !== want.ranged_value) begin
               $display("%0t: ranged_value expected %h actual %h", $time,
                        want.ranged_value, rsp_ranged_value);
               error_count++;
            end
            if (rsp_span_error !== want.span_error) begin
               $display("%0t: span_error expected %b actual %b", $time,
                        want.span_error, rsp_span_error);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_xoshiro256ss_random_generator_top: FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] random_bound();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 40) - 20;
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // Before any reseed the state is all zero, so raw draws return zero and bounded draws return the low bound.
   task automatic test_unseeded_state();
      send_item(CMD_RAW, 64'd0, 32'd0, 32'd0);
      send_item(CMD_BOUNDED, 64'd0, -32'sd5, 32'sd5);
   endtask

   task automatic test_directed_cases();
      send_item(CMD_RESEED, 64'd0, 32'd0, 32'd0);
      send_item(CMD_RAW, 64'd0, 32'd0, 32'd0);
      send_item(CMD_RESEED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_RAW, 64'd0, 32'd0, 32'd0);
      send_item(CMD_BOUNDED, 64'd0, 32'sd7, 32'sd7);                  // equal bounds
      send_item(CMD_BOUNDED, 64'd0, 32'h8000_0000, 32'h7FFF_FFFF);    // full range
      send_item(CMD_BOUNDED, 64'd0, 32'h7FFF_FFFF, 32'h8000_0000);    // wrapped bounds
      send_item(CMD_BOUNDED, 64'd0, 32'sd0, -32'sd1);                 // zero span
      send_item(CMD_BOUNDED, 64'd0, 32'sd10, -32'sd10);               // reversed bounds
      send_item(CMD_BOUNDED, 64'd0, -32'sd3, 32'sd3);
      send_item(CMD_BOUNDED, 64'd0, 32'h8000_0000, 32'h8000_0000);
      send_item(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_item(CMD_RAW, 64'd0, 32'd0, 32'd0);
      send_item(CMD_RESEED, 64'h0123_4567_89AB_CDEF, 32'd0, 32'd0);
   endtask

   task automatic test_random_sequences();
      logic [1:0] cmd;
      logic [31:0] lo;
      repeat (1030) begin
         case ($urandom_range(0, 19)) inside
            0: cmd = CMD_RESEED;
            1: cmd = CMD_UNUSED;
            [2:8]: cmd = CMD_RAW;
            default: cmd = CMD_BOUNDED;
         endcase
         lo = random_bound();
         case ($urandom_range(0, 5))
            0: send_item(cmd, {$urandom, $urandom}, lo, lo);
            1: send_item(cmd, {$urandom, $urandom}, lo, lo - 32'd1);
            default: send_item(cmd, {$urandom, $urandom}, lo, random_bound());
         endcase
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unseeded_state();
      test_directed_cases();
      test_random_sequences();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d items over all commands, equal, reversed and zero-span bounds,",
               items_sent);
      $display("with random sender gaps and receiver stalls; %0d results checked.",
               results_seen);
      if (error_count == 0) $display("tb_xoshiro256ss_random_generator_top: PASS");
      else $display("tb_xoshiro256ss_random_generator_top: FAIL");
      $finish;
   end

endmodule
